@@ rtl/core/dpva_pkg.sv @@
// Package: shared constants, types and tables of the visibility accumulator.
package dpva_pkg;

  localparam int PhaseBits   = 16;
  localparam int AccBits     = 48;
  localparam int OutBits     = 48;
  localparam int CordicSteps = 16;
  localparam int QueueDepth  = 4;
  localparam int QueueAw     = $clog2(QueueDepth);

  localparam logic [31:0] CordicX0    = 32'd652032874;
  localparam logic [15:0] GainReset   = 16'd4096;
  localparam logic [1:0]  RegGain     = 2'd0;

  // One classified item: conj product and the kept phase word.
  typedef struct packed {
    logic signed [33:0] pr;
    logic signed [33:0] pi;
    logic [31:0]        w;
    logic               last;
  } dpva_work_t;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] r;
    begin
      case (i)
        4'd0:  r = 32'd536870912;
        4'd1:  r = 32'd316933406;
        4'd2:  r = 32'd167458907;
        4'd3:  r = 32'd85004756;
        4'd4:  r = 32'd42667331;
        4'd5:  r = 32'd21354465;
        4'd6:  r = 32'd10679838;
        4'd7:  r = 32'd5340247;
        4'd8:  r = 32'd2670163;
        4'd9:  r = 32'd1335087;
        4'd10: r = 32'd667544;
        4'd11: r = 32'd333772;
        4'd12: r = 32'd166886;
        4'd13: r = 32'd83443;
        4'd14: r = 32'd41722;
        4'd15: r = 32'd20861;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // Round Q4.30 to Q1.15 and saturate.
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] x);
    logic signed [34:0] t;
    logic signed [19:0] r;
    begin
      t = 35'(x) + 35'sd16384;
      r = 20'(t >>> 15);
      if (r > 20'sd32767) return 16'sh7fff;
      else if (r < -20'sd32768) return 16'sh8000;
      else return r[15:0];
    end
  endfunction

endpackage

@@ rtl/core/delay_phase_visibility_accumulator.sv @@
// Top level: fringe-rotated cross-correlation accumulator.
//   channel  | handshake           | payload
//   in       | in_valid/in_stall   | amp_a_*, amp_b_*, delay_a/b, freq, last
//   out      | out_valid/out_stall | vis_re, vis_im
//   cfg      | APB psel/penable    | output_gain at address 0
// The back end takes one item at a time (load, 16 CORDIC steps, rotate,
// multiply, accumulate), plus output on a last item; CORDIC sets the rate.
// The front and 4-entry queue keep taking items until the queue is full.
// Reset clears sums, queue and gain (1.0); out_stall holds the result.
module delay_phase_visibility_accumulator
  import dpva_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] amp_a_re,
  input  logic signed [15:0] amp_a_im,
  input  logic signed [15:0] amp_b_re,
  input  logic signed [15:0] amp_b_im,
  input  logic signed [31:0] delay_a,
  input  logic signed [31:0] delay_b,
  input  logic [31:0]        freq,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] vis_re,
  output logic signed [47:0] vis_im,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        take, push, pop, q_full, q_empty;
  dpva_work_t  push_data, head;
  logic [15:0] gain;

  assign in_stall = !take;
  assign pready = 1'b1;
  assign prdata = (paddr == RegGain) ? {16'd0, gain} : 32'd0;

  // Hold gain until an APB write to its address.
  always_ff @(posedge clk) begin
    if (rst) gain <= GainReset;
    else if (psel && penable && pwrite && paddr == RegGain) gain <= pwdata[15:0];
  end

  dpva_front u_front (
    .clk, .rst, .in_valid, .amp_a_re, .amp_a_im, .amp_b_re, .amp_b_im,
    .delay_a, .delay_b, .freq, .last, .q_full, .take, .push, .push_data
  );

  dpva_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .full(q_full), .empty(q_empty), .head
  );

  dpva_back u_back (
    .clk, .rst, .q_empty, .head, .pop, .gain, .out_valid, .out_stall, .vis_re, .vis_im
  );

endmodule

@@ rtl/core/dpva_front.sv @@
// Front: takes items, forms the conj product and the phase word.
module dpva_front
  import dpva_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] amp_a_re,
  input  logic signed [15:0] amp_a_im,
  input  logic signed [15:0] amp_b_re,
  input  logic signed [15:0] amp_b_im,
  input  logic signed [31:0] delay_a,
  input  logic signed [31:0] delay_b,
  input  logic [31:0]        freq,
  input  logic               last,
  input  logic               q_full,
  output logic               take,
  output logic               push,
  output dpva_work_t         push_data
);

  localparam logic [31:0] Keep = ~((32'd1 << (32 - PhaseBits)) - 32'd1);

  logic               s1_valid;
  logic signed [31:0] s1_prr, s1_pii, s1_pir, s1_pri;
  logic [31:0]        s1_diff, s1_freq;
  logic               s1_last;
  logic [31:0]        wprod;

  // Single stage: advance only when the queue has room.
  assign take = !q_full && !(s1_valid && q_full);
  assign push = s1_valid && !q_full;
  assign wprod = s1_freq * s1_diff;
  assign push_data.pr = 34'(s1_prr) + 34'(s1_pii);
  assign push_data.pi = 34'(s1_pir) - 34'(s1_pri);
  assign push_data.w = wprod & Keep;
  assign push_data.last = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!q_full) begin
      s1_valid <= in_valid;
    end
    if (!q_full) begin
      s1_prr  <= amp_a_re * amp_b_re;
      s1_pii  <= amp_a_im * amp_b_im;
      s1_pir  <= amp_a_im * amp_b_re;
      s1_pri  <= amp_a_re * amp_b_im;
      s1_diff <= delay_a - delay_b;
      s1_freq <= freq;
      s1_last <= last;
    end
  end

endmodule

@@ rtl/core/dpva_queue.sv @@
// Queue: short FIFO between front and back.
module dpva_queue
  import dpva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  dpva_work_t push_data,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output dpva_work_t head
);

  dpva_work_t           mem [QueueDepth];
  logic [QueueAw-1:0]   wp, rp;
  logic [QueueAw:0]     cnt;

  assign full  = (cnt == (QueueAw+1)'(QueueDepth));
  assign empty = (cnt == '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
    if (push) mem[wp] <= push_data;
  end

endmodule

@@ rtl/core/dpva_back.sv @@
// Back: CORDIC rotator, rotate, accumulate, scale on last.
module dpva_back
  import dpva_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  dpva_work_t         head,
  output logic               pop,
  input  logic [15:0]        gain,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] vis_re,
  output logic signed [47:0] vis_im
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROT   = 6'b000010,
    ST_MULT  = 6'b000100,
    ST_ACC   = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t             state;
  dpva_work_t         cur;
  logic [3:0]         step;
  logic signed [33:0] x, y, z;
  logic signed [15:0] c, s;
  logic signed [49:0] m_rc, m_is, m_rs, m_ic;
  logic signed [AccBits-1:0] sum_re, sum_im;
  logic [63:0]        mag_re, mag_im;
  logic               neg_re, neg_im;
  logic signed [33:0] cx, cy;
  logic signed [33:0] dx, dy;
  logic signed [51:0] t_re, t_im;
  logic signed [AccBits+1:0] a_re, a_im;
  logic [79:0]        p_re, p_im;

  localparam logic signed [AccBits+1:0] AccHi = (AccBits+2)'((65'sd1 <<< (AccBits-1)) - 1);
  localparam logic signed [AccBits+1:0] AccLo = -AccHi - 1;

  function automatic logic signed [AccBits-1:0] sat_acc(input logic signed [AccBits+1:0] v);
    if (v > AccHi) return AccHi[AccBits-1:0];
    else if (v < AccLo) return AccLo[AccBits-1:0];
    else return v[AccBits-1:0];
  endfunction

  function automatic logic [47:0] scale(input logic [79:0] p, input logic neg);
    logic [79:0] r;
    begin
      r = (p + 80'd2048) >> 12;
      if (p >= (80'd1 << 60) || (neg ? (r > 80'h8000_0000_0000) : (r > 80'h7fff_ffff_ffff)))
        return neg ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
      return neg ? 48'(-r) : r[47:0];
    end
  endfunction

  assign pop = (state == ST_IDLE) && !q_empty;
  assign dx = y >>> step;
  assign dy = x >>> step;
  always_comb begin
    case (cur.w[31:30])
      2'd0: begin cx = x;  cy = y;  end
      2'd1: begin cx = -y; cy = x;  end
      2'd2: begin cx = -x; cy = -y; end
      default: begin cx = y; cy = -x; end
    endcase
  end
  assign t_re = (52'(m_rc) - 52'(m_is) + 52'sd16384) >>> 15;
  assign t_im = (52'(m_rs) + 52'(m_ic) + 52'sd16384) >>> 15;
  assign a_re = (AccBits+2)'(sum_re) + (AccBits+2)'(t_re);
  assign a_im = (AccBits+2)'(sum_im) + (AccBits+2)'(t_im);
  assign p_re = 80'(mag_re) * 80'(gain);
  assign p_im = 80'(mag_im) * 80'(gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sum_re <= '0;
      sum_im <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (pop) begin
          cur <= head;
          x <= 34'(CordicX0);
          y <= '0;
          z <= 34'({2'b00, head.w[29:0]});
          step <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (!z[33]) begin
            x <= x - dx; y <= y + dy; z <= z - 34'(atan_turn(step));
          end else begin
            x <= x + dx; y <= y - dy; z <= z + 34'(atan_turn(step));
          end
          step <= step + 4'd1;
          if (step == 4'(CordicSteps - 1)) state <= ST_MULT;
        end
        ST_MULT: begin
          c <= to_q15(cx);
          s <= to_q15(cy);
          state <= ST_ACC;
        end
        ST_ACC: begin
          m_rc <= cur.pr * c; m_is <= cur.pi * s;
          m_rs <= cur.pr * s; m_ic <= cur.pi * c;
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          sum_re <= sat_acc(a_re);
          sum_im <= sat_acc(a_im);
          neg_re <= a_re < 0;
          neg_im <= a_im < 0;
          mag_re <= 64'(sat_acc(a_re) < 0 ? -(AccBits+2)'(sat_acc(a_re)) : (AccBits+2)'(sat_acc(a_re)));
          mag_im <= 64'(sat_acc(a_im) < 0 ? -(AccBits+2)'(sat_acc(a_im)) : (AccBits+2)'(sat_acc(a_im)));
          state <= cur.last ? ST_OUT : ST_IDLE;
        end
        ST_OUT: if (!out_valid || !out_stall) begin
          vis_re <= scale(p_re, neg_re);
          vis_im <= scale(p_im, neg_im);
          sum_re <= '0;
          sum_im <= '0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/dpva_checker.sv @@
// Checker: port-level assertions bound to the top level.
module dpva_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] vis_re,
  input logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vis_re)) else $error("out held");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
endmodule

bind delay_phase_visibility_accumulator dpva_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .vis_re, .pready
);

@@ test/delay_phase_visibility_accumulator_tb.sv @@
// Testbench: checks the visibility accumulator against a cycle-free predictor.
`timescale 1ns / 100ps

module delay_phase_visibility_accumulator_tb;
  import dpva_pkg::*;

  localparam int IdleLimit  = 5000;   // cycles with no accepted item or result
  localparam int DrainWait  = 160;    // cycles to let the back end settle after a drain
  localparam int HoldCycles = 400;

  typedef struct {
    logic signed [15:0] a_re, a_im, b_re, b_im;
    logic signed [31:0] dly_a, dly_b;
    logic [31:0]        freq;
    logic               last;
  } term_t;

  typedef struct {
    logic signed [47:0] re, im;
  } vis_t;

  // Rotation angles of the CORDIC steps, in 2^-32 turn units.
  localparam longint AtanTurns[CordicSteps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340247, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] amp_a_re = '0, amp_a_im = '0, amp_b_re = '0, amp_b_im = '0;
  logic signed [31:0] delay_a = '0, delay_b = '0;
  logic [31:0] freq = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] vis_re, vis_im;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor state: running sums and the gain register.
  longint sum_re_q, sum_im_q;
  logic [15:0] gain_q;
  vis_t vis_expected[$];

  int n_items, n_results, n_errors, idle_cycles, burst_left, hold_left;
  bit timed_out;

  delay_phase_visibility_accumulator dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint round_q15(input longint x);
    longint r;
    r = (x + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Turn a phase word into cos and sin, Q1.15.
  function automatic void fringe_rotator(input logic [31:0] w, output longint c,
                                          output longint s);
    longint x, y, z, dx, dy;
    x = CordicX0;
    y = 0;
    z = longint'(w & 32'h3FFF_FFFF);
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurns[i];
      end else begin
        x += dx; y -= dy; z += AtanTurns[i];
      end
    end
    case (w[31:30])
      2'd0: begin c = round_q15(x);  s = round_q15(y);  end
      2'd1: begin c = round_q15(-y); s = round_q15(x);  end
      2'd2: begin c = round_q15(-x); s = round_q15(-y); end
      default: begin c = round_q15(y); s = round_q15(-x); end
    endcase
  endfunction

  function automatic longint sat_acc(input longint acc, input longint t);
    longint hi, lo, r;
    hi = (longint'(1) <<< (AccBits - 1)) - 1;
    lo = -hi - 1;
    r = acc + t;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  // Scale a sum by the Q4.12 gain, round half away from zero, clamp to 48 bits.
  function automatic logic signed [47:0] scale_sum(input longint v, input logic [15:0] g);
    bit neg;
    logic [63:0] m, p, r, lim;
    neg = v < 0;
    m = neg ? 64'(-v) : 64'(v);
    lim = 64'd1 << (OutBits - 1);
    if (g == 0 || m == 0) return '0;
    p = m * 64'(g);
    r = (p + 64'd2048) >> 12;
    if (p >= (64'd1 << 60) || (neg ? (r > lim) : (r > lim - 1)))
      return neg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    return neg ? -48'(r) : 48'(r);
  endfunction

  // Fold one accepted term into the sums; queue a visibility on a last term.
  function automatic void accumulate_term(input term_t t);
    logic [31:0] dd, w;
    logic [63:0] prod;
    longint c, s, pr, pi, tr, ti;
    vis_t v;
    dd = t.dly_a - t.dly_b;
    prod = 64'(t.freq) * 64'(dd);
    w = prod[31:0] & ~((32'd1 << (32 - PhaseBits)) - 1);
    fringe_rotator(w, c, s);
    pr = longint'(t.a_re) * t.b_re + longint'(t.a_im) * t.b_im;
    pi = longint'(t.a_im) * t.b_re - longint'(t.a_re) * t.b_im;
    tr = (pr * c - pi * s + 16384) >>> 15;
    ti = (pr * s + pi * c + 16384) >>> 15;
    sum_re_q = sat_acc(sum_re_q, tr);
    sum_im_q = sat_acc(sum_im_q, ti);
    if (t.last) begin
      v.re = scale_sum(sum_re_q, gain_q);
      v.im = scale_sum(sum_im_q, gain_q);
      vis_expected.push_back(v);
      sum_re_q = 0;
      sum_im_q = 0;
    end
  endfunction

  // ------------------------------------------------------------- driver tasks
  // Offer one item; hold it until accepted. Gaps fall between random bursts.
  task automatic send_term(input term_t t);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    amp_a_re <= t.a_re; amp_a_im <= t.a_im;
    amp_b_re <= t.b_re; amp_b_im <= t.b_im;
    delay_a <= t.dly_a; delay_b <= t.dly_b;
    freq <= t.freq; last <= t.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_term(t);
    n_items++;
    burst_left--;
  endtask

  // Drop valid, let every expected visibility arrive, then let the back end settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (vis_expected.size() != 0 && !timed_out) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_gain(input logic [15:0] g);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 2'(RegGain * 4); pwdata <= {16'd0, g};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    gain_q = g;
    @(posedge clk);
  endtask

  function automatic term_t random_term(input bit is_last);
    term_t t;
    t.a_re = 16'($urandom); t.a_im = 16'($urandom);
    t.b_re = 16'($urandom); t.b_im = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      t.a_re = 16'sh8000; t.b_re = 16'sh8000;
    end
    t.dly_a = $urandom; t.dly_b = $urandom;
    t.freq = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom;
    t.last = is_last;
    return t;
  endfunction

  // Send sums of random length, each ending on a last term.
  task automatic send_random_sums(input int n);
    int k;
    k = 0;
    while (k < n) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int j = 0; j < len; j++) send_term(random_term(j == len - 1));
      k += len;
    end
  endtask

  // --------------------------------------------------------------- test tasks
  task automatic test_directed;
    term_t t;
    logic [31:0] quarter[4] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000};
    // Each quadrant of the phase, one term per sum, unit gain.
    foreach (quarter[q]) begin
      t = '{16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh0000, $signed(quarter[q]), 32'sd0,
            32'd1, 1'b1};
      send_term(t);
    end
    // Field extremes: most negative amplitudes, extreme delays and frequency.
    t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'hFFFF_FFFF, 1'b0};
    send_term(t);
    t = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'h0, 1'b1};
    send_term(t);
    t = '{16'sh0, 16'sh0, 16'sh0, 16'sh0, 32'sh0, 32'sh0, 32'h0, 1'b1};
    send_term(t);
    // Phase bits just below and at the kept boundary.
    t = '{16'sh4000, 16'sh1234, 16'sh8000, 16'shEDCB, 32'sh0000_FFFF, 32'sh0,
          32'd1, 1'b1};
    send_term(t);
    t = '{16'sh4000, 16'sh1234, 16'sh8000, 16'shEDCB, 32'sh0001_0000, 32'sh0,
          32'd1, 1'b1};
    send_term(t);
    drain();
    // Zero gain: terms still accumulate, the visibility comes out as zero.
    write_gain(16'd0);
    for (int j = 0; j < 4; j++) send_term(random_term(j == 3));
    drain();
    // Largest gain on a sum of full-scale terms.
    write_gain(16'hFFFF);
    t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh0, 32'sh0, 32'h0, 1'b0};
    for (int j = 0; j < 6; j++) send_term(t);
    t.last = 1'b1;
    send_term(t);
    drain();
  endtask

  task automatic test_gain_sweep;
    logic [15:0] gains[5] = '{16'd4096, 16'd1, 16'hFFFF, 16'd0, 16'd12288};
    foreach (gains[i]) begin
      write_gain(gains[i]);
      send_random_sums(90);
      drain();
    end
    write_gain(16'($urandom));
    send_random_sums(90);
    drain();
  endtask

  // Hold off the receiver long enough that the queue fills and stalls the input.
  task automatic test_backpressure;
    write_gain(16'd4096);
    hold_left = HoldCycles;
    send_random_sums(80);
    drain();
  endtask

  // ---------------------------------------------------------------- receiver
  int stall_phase;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_phase[7]) begin
      out_stall <= 1'b0;   // stretch with no stalls
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // Compare each accepted visibility with the oldest one predicted.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (vis_expected.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: visibility with none expected: re=%0d im=%0d", $time, vis_re, vis_im);
      end else begin
        vis_t v;
        v = vis_expected.pop_front();
        if (vis_re !== v.re || vis_im !== v.im) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: visibility mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                     $time, v.re, v.im, vis_re, vis_im);
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        timed_out = 1'b1;
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("** delay_phase_visibility_accumulator: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    sum_re_q = 0;
    sum_im_q = 0;
    gain_q = GainReset;
    burst_left = 0;
    hold_left = 0;
    stall_phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gain_sweep();
    test_backpressure();
    $display("covered %0d terms and %0d visibilities over six gain settings,", n_items,
             n_results);
    $display("quadrant and field extremes, zero and full-scale gain, and a long output stall");
    if (n_errors == 0 && vis_expected.size() == 0) begin
      $display("** delay_phase_visibility_accumulator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d visibilities still expected", n_errors,
               vis_expected.size());
      $display("** delay_phase_visibility_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
